[hw/rtl/mbe_pkg.sv]
// ----------------------------------------------------------------------------
// mbe_pkg
// shared types and constants of the escape-time core
// ----------------------------------------------------------------------------
`default_nettype none
package mbe_pkg;
   localparam int FracBits = 28;
   localparam int CountWidth = 20;
   localparam int LimitWidth = 35;
   localparam int PixWidth = 12;
   localparam int NumCells = 4;

   typedef enum logic [2:0] {
      CSR_LEFT_REAL = 3'd0,
      CSR_TOP_IMAG = 3'd1,
      CSR_PIXEL_STEP = 3'd2,
      CSR_ESCAPE_LIMIT = 3'd3,
      CSR_MAX_ITERATIONS = 3'd4
   } csr_index_type;

   // token handed from cell to cell
   typedef struct packed {
      logic                    busy;
      logic                    done;
      logic                    escaped;
      logic [CountWidth-1:0]   count;
      logic signed [31:0]      zr;
      logic signed [31:0]      zi;
      logic signed [31:0]      cr;
      logic signed [31:0]      ci;
   } token_type;

   typedef struct packed {
      logic [LimitWidth-1:0] limit;
      logic [CountWidth-1:0] max_iter;
   } cell_cfg_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction
endpackage
`default_nettype wire

[hw/rtl/mbe_if.sv]
// ----------------------------------------------------------------------------
// mbe_if
// valid/ready channel with a generic payload
// ----------------------------------------------------------------------------
`default_nettype none
interface mbe_if #(parameter int Width = 1);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/mbe_cell.sv]
// ----------------------------------------------------------------------------
// mbe_cell
// one iteration stage of the ring: square, test, update, pass on
// ----------------------------------------------------------------------------
`default_nettype none
module mbe_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire mbe_pkg::cell_cfg_type cfg,
   input  wire mbe_pkg::token_type tok_in,
   output mbe_pkg::token_type      tok_out
);
   import mbe_pkg::*;

   // stage 1: products; stage 2: update
   token_type          s1_ff, s1_in, s2_in;
   logic signed [63:0] rr_ff, ii_ff, ri_ff;
   logic [35:0]        mag;
   logic signed [63:0] dr, nr64, ni64;

   always_comb begin
      s1_in = tok_in;
      // stop tests run in the update stage on registered squares
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.busy <= 1'b0;
      end else begin
         s1_ff.busy <= s1_in.busy;
      end
      s1_ff.done <= s1_in.done;
      s1_ff.escaped <= s1_in.escaped;
      s1_ff.count <= s1_in.count;
      s1_ff.zr <= s1_in.zr;
      s1_ff.zi <= s1_in.zi;
      s1_ff.cr <= s1_in.cr;
      s1_ff.ci <= s1_in.ci;
      rr_ff <= tok_in.zr * tok_in.zr;
      ii_ff <= tok_in.zi * tok_in.zi;
      ri_ff <= tok_in.zr * tok_in.zi;
   end

   always_comb begin
      s2_in = s1_ff;
      // squares are non-negative and below 2^63, so 36 bits hold the sum
      mag = rr_ff[63:FracBits] + ii_ff[63:FracBits];
      dr = rr_ff - ii_ff;
      nr64 = (dr >>> FracBits) + 64'(s1_ff.cr);
      ni64 = (ri_ff >>> (FracBits - 1)) + 64'(s1_ff.ci);
      if (s1_ff.busy && !s1_ff.done) begin
         if (s1_ff.count == cfg.max_iter) begin
            s2_in.done = 1'b1;
            s2_in.escaped = 1'b0;
         end else if (mag >= {1'b0, cfg.limit}) begin
            s2_in.done = 1'b1;
            s2_in.escaped = 1'b1;
         end else begin
            s2_in.zr = sat32(nr64);
            s2_in.zi = sat32(ni64);
            s2_in.count = s1_ff.count + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_out.busy <= 1'b0;
      end else begin
         tok_out.busy <= s2_in.busy;
      end
      tok_out.done <= s2_in.done;
      tok_out.escaped <= s2_in.escaped;
      tok_out.count <= s2_in.count;
      tok_out.zr <= s2_in.zr;
      tok_out.zi <= s2_in.zi;
      tok_out.cr <= s2_in.cr;
      tok_out.ci <= s2_in.ci;
   end
endmodule
`default_nettype wire

[hw/rtl/mandelbrot_escape_time_core.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_core
// escape-time evaluator for one pixel per transaction
// ----------------------------------------------------------------------------
// req channel carries pixel_x / pixel_y; rsp channel returns iteration_count
// and escaped; csr channel writes the five registers by index (others ignored)
// a pixel is first mapped to c (a registered multiply, then a registered add
// with saturation), then enters a ring of cells, each doing one iteration as
// products, then update; the token circles the ring until the cap or the
// escape limit stops it; only one pixel is in flight at a time
// a finished result sits in the rsp register; the next request is taken
// while it waits, but the ring cannot hand off a second result until it is
// taken, so a stalled receiver holds the ring
// reset restores the register defaults and empties the ring
// ----------------------------------------------------------------------------
`default_nettype none
module mandelbrot_escape_time_core (
   input wire logic clock,
   input wire logic reset,
   mbe_if.sink      req,
   mbe_if.source    rsp,
   mbe_if.sink      csr
);
   import mbe_pkg::*;

   // csr payload: {index[2:0], data[34:0]}; req: {pixel_y, pixel_x}
   // rsp: {escaped, iteration_count}, the count zeroed when not escaped
   logic signed [31:0]    left_real_ff, top_imag_ff;
   logic [30:0]           pixel_step_ff;
   logic [LimitWidth-1:0] escape_limit_ff;
   logic [CountWidth-1:0] max_iter_ff;
   logic [2:0]            csr_idx;
   cell_cfg_type          cfg;

   assign csr.ready = 1'b1;
   assign csr_idx = csr.data[37:35];
   assign cfg = '{limit: escape_limit_ff, max_iter: max_iter_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         left_real_ff <= -32'sd536870912;
         top_imag_ff <= -32'sd295279002;
         pixel_step_ff <= 31'd125829;
         escape_limit_ff <= 35'd1073741824;
         max_iter_ff <= 20'd1000000;
      end else if (csr.valid) begin
         case (csr_idx)
            CSR_LEFT_REAL: left_real_ff <= csr.data[31:0];
            CSR_TOP_IMAG: top_imag_ff <= csr.data[31:0];
            CSR_PIXEL_STEP: pixel_step_ff <= csr.data[30:0];
            CSR_ESCAPE_LIMIT: escape_limit_ff <= csr.data[34:0];
            CSR_MAX_ITERATIONS: max_iter_ff <= csr.data[19:0];
            default: ;
         endcase
      end
   end

   // one pixel in flight: from acceptance until its result is loaded
   logic busy_ff, busy_in;
   logic map1_ff, map2_ff;
   logic [42:0] px_ff, py_ff;
   logic signed [31:0] cr_ff, ci_ff;
   logic rsp_valid_ff, rsp_valid_in;
   logic [CountWidth:0] rsp_data_ff;
   token_type ring [NumCells];
   token_type inject, head;
   logic load_out;

   assign req.ready = !busy_ff;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_data_ff;

   // mapping: multiply, then add and saturate
   always_ff @(posedge clock) begin
      if (reset) begin
         map1_ff <= 1'b0;
         map2_ff <= 1'b0;
      end else begin
         map1_ff <= req.valid && req.ready;
         map2_ff <= map1_ff;
      end
      px_ff <= req.data[11:0] * pixel_step_ff;
      py_ff <= req.data[23:12] * pixel_step_ff;
      cr_ff <= sat32(64'(left_real_ff) + 64'(px_ff));
      ci_ff <= sat32(64'(top_imag_ff) + 64'(py_ff));
   end

   // tail of the ring feeds the head unless it is loaded into rsp or a new pixel enters
   assign head = ring[NumCells-1];
   assign load_out = head.busy && head.done && !(rsp_valid_ff && !rsp.ready);

   always_comb begin
      inject = head;
      if (map2_ff) begin
         inject = '{busy: 1'b1, done: 1'b0, escaped: 1'b0, count: '0,
                    zr: '0, zi: '0, cr: cr_ff, ci: ci_ff};
      end else if (load_out) begin
         inject.busy = 1'b0;
      end
   end

   for (genvar g = 0; g < NumCells; g++) begin : g_cell
      mbe_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .cfg    (cfg),
         .tok_in ((g == 0) ? inject : ring[(g == 0) ? 0 : g-1]),
         .tok_out(ring[g])
      );
   end

   always_comb begin
      busy_in = busy_ff;
      if (req.valid && req.ready) busy_in = 1'b1;
      else if (load_out) busy_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp.ready) rsp_valid_in = 1'b0;
      if (load_out) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load_out) begin
         rsp_data_ff <= {head.escaped, (head.escaped ? head.count : {CountWidth{1'b0}})};
      end
   end
endmodule
`default_nettype wire
